[rtl/core/siphash_counter_drbg_macros.svh]
// Assertion macros shared by the SipHash counter DRBG RTL.
// Pulled in with an include by the modules that carry assertions; no dependencies.
`ifndef SIPHASH_COUNTER_DRBG_MACROS_SVH
`define SIPHASH_COUNTER_DRBG_MACROS_SVH

// same-cycle implication, disabled during reset
`define SHDRBG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shdrbg assertion failed");

// next-cycle implication, disabled during reset
`define SHDRBG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shdrbg assertion failed");

`endif

[rtl/core/shdrbg_pkg.sv]
// Package for the SipHash-2-4 counter DRBG: constants, lane types, half-round functions.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package shdrbg_pkg;

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned RAND_W     = 32;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [WORD_W-1:0] SIP_INIT0     = 64'h736f6d6570736575;
  localparam logic [WORD_W-1:0] SIP_INIT1     = 64'h646f72616e646f6d;
  localparam logic [WORD_W-1:0] SIP_INIT2     = 64'h6c7967656e657261;
  localparam logic [WORD_W-1:0] SIP_INIT3     = 64'h7465646279746573;
  localparam logic [WORD_W-1:0] SIP_LEN_BLOCK = 64'h0800000000000000;
  localparam logic [WORD_W-1:0] SIP_FINAL_XOR = 64'h00000000000000ff;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_KEY_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_SECOND = 1'b1;

  // one pipeline stage per half round: 2 + 2 compression rounds, 4 final rounds
  localparam int unsigned NUM_STAGES     = 16;
  localparam int unsigned STAGE_MSG_END  = 4;   // counter block done, length block starts
  localparam int unsigned STAGE_LEN_END  = 8;   // length block done, finalization starts

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
  } lanes_t;

  typedef struct packed {
    logic [WORD_W-1:0] idx;
    lanes_t            lanes;
  } item_t;

  function automatic logic [WORD_W-1:0] rotl13(input logic [WORD_W-1:0] x);
    rotl13 = {x[WORD_W-14:0], x[WORD_W-1:WORD_W-13]};
  endfunction

  function automatic logic [WORD_W-1:0] rotl16(input logic [WORD_W-1:0] x);
    rotl16 = {x[WORD_W-17:0], x[WORD_W-1:WORD_W-16]};
  endfunction

  function automatic logic [WORD_W-1:0] rotl17(input logic [WORD_W-1:0] x);
    rotl17 = {x[WORD_W-18:0], x[WORD_W-1:WORD_W-17]};
  endfunction

  function automatic logic [WORD_W-1:0] rotl21(input logic [WORD_W-1:0] x);
    rotl21 = {x[WORD_W-22:0], x[WORD_W-1:WORD_W-21]};
  endfunction

  function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x);
    rotl32 = {x[WORD_W-33:0], x[WORD_W-1:WORD_W-32]};
  endfunction

  // first half of SipRound: a+=b and c+=d side by side
  function automatic lanes_t half_a(input lanes_t s);
    lanes_t r;
    logic [WORD_W-1:0] sa;
    logic [WORD_W-1:0] sc;
    sa  = s.a + s.b;
    sc  = s.c + s.d;
    r.b = rotl13(s.b) ^ sa;
    r.a = rotl32(sa);
    r.d = rotl16(s.d) ^ sc;
    r.c = sc;
    half_a = r;
  endfunction

  // second half of SipRound: a+=d and c+=b side by side
  function automatic lanes_t half_b(input lanes_t s);
    lanes_t r;
    logic [WORD_W-1:0] sa;
    logic [WORD_W-1:0] sc;
    sa  = s.a + s.d;
    sc  = s.c + s.b;
    r.d = rotl21(s.d) ^ sa;
    r.a = sa;
    r.b = rotl17(s.b) ^ sc;
    r.c = rotl32(sc);
    half_b = r;
  endfunction

endpackage

[rtl/core/shdrbg_stage.sv]
// One pipeline stage of the SipHash-2-4 datapath: block injection plus one half round.
// Depends on shdrbg_pkg.
`timescale 1ns / 1ps

module shdrbg_stage #(
  parameter int unsigned STAGE = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  shdrbg_pkg::item_t   in_item,
  output logic                out_valid,
  output shdrbg_pkg::item_t   out_item
);

  logic                valid_r;
  shdrbg_pkg::item_t   item_r;
  shdrbg_pkg::lanes_t  pre;
  shdrbg_pkg::item_t   item_nxt;

  always_comb begin
    pre = in_item.lanes;
    if (STAGE == 0) begin
      pre.d = pre.d ^ in_item.idx;
    end
    if (STAGE == shdrbg_pkg::STAGE_MSG_END) begin
      // close the counter block, open the length block
      pre.a = pre.a ^ in_item.idx;
      pre.d = pre.d ^ shdrbg_pkg::SIP_LEN_BLOCK;
    end
    if (STAGE == shdrbg_pkg::STAGE_LEN_END) begin
      pre.a = pre.a ^ shdrbg_pkg::SIP_LEN_BLOCK;
      pre.c = pre.c ^ shdrbg_pkg::SIP_FINAL_XOR;
    end
    item_nxt.idx = in_item.idx;
    if ((STAGE % 2) == 0) begin
      item_nxt.lanes = shdrbg_pkg::half_a(pre);
    end else begin
      item_nxt.lanes = shdrbg_pkg::half_b(pre);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

[rtl/core/shdrbg_outbuf.sv]
// Output register with skid slot for the DRBG; folds the four lanes into the result word.
// Depends on shdrbg_pkg.
`timescale 1ns / 1ps

module shdrbg_outbuf (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push_valid,
  input  shdrbg_pkg::item_t                  push_item,
  output logic                               push_ready,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [shdrbg_pkg::RAND_W-1:0]      out_random_word,
  output logic [shdrbg_pkg::WORD_W-1:0]      out_sequence_index
);

  logic                               out_valid_r;
  logic [shdrbg_pkg::RAND_W-1:0]      word_r;
  logic [shdrbg_pkg::WORD_W-1:0]      idx_r;
  logic                               skid_valid_r;
  logic [shdrbg_pkg::RAND_W-1:0]      skid_word_r;
  logic [shdrbg_pkg::WORD_W-1:0]      skid_idx_r;
  logic [shdrbg_pkg::WORD_W-1:0]      fold;
  logic                               push;
  logic                               drain;

  assign fold  = push_item.lanes.a ^ push_item.lanes.b ^ push_item.lanes.c ^ push_item.lanes.d;
  assign push  = push_valid && push_ready;
  assign drain = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (drain) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      if (skid_valid_r) begin
        word_r <= skid_word_r;
        idx_r  <= skid_idx_r;
      end else begin
        word_r <= fold[shdrbg_pkg::RAND_W-1:0];
        idx_r  <= push_item.idx;
      end
    end else if (push) begin
      skid_word_r <= fold[shdrbg_pkg::RAND_W-1:0];
      skid_idx_r  <= push_item.idx;
    end
  end

  assign push_ready         = !skid_valid_r;
  assign out_valid          = out_valid_r;
  assign out_random_word    = word_r;
  assign out_sequence_index = idx_r;

endmodule

[rtl/core/siphash_counter_drbg.sv]
// SipHash-2-4 counter DRBG: one 32-bit word per request with in_advance high,
// counter wraps modulo 2^64.
// Throughput: one item per cycle; 16 half-round stages plus an output skid slot.
// A stalled output freezes the whole pipeline once the skid slot fills.
// Reset (synchronous, rst_n low): counter and both keys cleared, pipeline emptied.
`timescale 1ns / 1ps

module siphash_counter_drbg (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [shdrbg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [shdrbg_pkg::WORD_W-1:0]          cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_advance,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [shdrbg_pkg::RAND_W-1:0]          out_random_word,
  output logic [shdrbg_pkg::WORD_W-1:0]          out_sequence_index
);

  `include "siphash_counter_drbg_macros.svh"

  localparam int unsigned NS = shdrbg_pkg::NUM_STAGES;

  logic [shdrbg_pkg::WORD_W-1:0] key_first_r;
  logic [shdrbg_pkg::WORD_W-1:0] key_second_r;
  logic [shdrbg_pkg::WORD_W-1:0] counter_r;
  logic [shdrbg_pkg::WORD_W-1:0] counter_nxt;
  logic                          in_valid_r;
  logic [shdrbg_pkg::WORD_W-1:0] in_idx_r;
  logic                          en;
  logic                          take;
  shdrbg_pkg::item_t             head_item;
  logic                          pipe_valid [NS];
  shdrbg_pkg::item_t             pipe_item  [NS];

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_first_r  <= '0;
      key_second_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        shdrbg_pkg::REG_KEY_FIRST:  key_first_r  <= cfg_wdata;
        shdrbg_pkg::REG_KEY_SECOND: key_second_r <= cfg_wdata;
      endcase
    end
  end

  assign in_ready    = en;
  assign take        = in_valid && in_ready && in_advance;
  assign counter_nxt = counter_r + 64'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r  <= '0;
      in_valid_r <= 1'b0;
    end else if (en) begin
      in_valid_r <= take;
      if (take) begin
        counter_r <= counter_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_idx_r <= counter_r;
    end
  end

  // user must change keys only while idle, unenforced; lanes come straight from them
  always_comb begin
    head_item.idx     = in_idx_r;
    head_item.lanes.a = shdrbg_pkg::SIP_INIT0 ^ key_first_r;
    head_item.lanes.b = shdrbg_pkg::SIP_INIT1 ^ key_second_r;
    head_item.lanes.c = shdrbg_pkg::SIP_INIT2 ^ key_first_r;
    head_item.lanes.d = shdrbg_pkg::SIP_INIT3 ^ key_second_r;
  end

  for (genvar g = 0; g < NS; g++) begin : g_stage
    if (g == 0) begin : g_head
      shdrbg_stage #(.STAGE(g)) u_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid_r),
        .in_item   (head_item),
        .out_valid (pipe_valid[g]),
        .out_item  (pipe_item[g])
      );
    end else begin : g_body
      shdrbg_stage #(.STAGE(g)) u_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pipe_valid[g-1]),
        .in_item   (pipe_item[g-1]),
        .out_valid (pipe_valid[g]),
        .out_item  (pipe_item[g])
      );
    end
  end

  shdrbg_outbuf u_outbuf (
    .clk                (clk),
    .rst_n              (rst_n),
    .push_valid         (pipe_valid[NS-1]),
    .push_item          (pipe_item[NS-1]),
    .push_ready         (en),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_random_word    (out_random_word),
    .out_sequence_index (out_sequence_index)
  );

  `SHDRBG_ASSERT_NEXT(a_counter_step, clk, rst_n, take, counter_r == $past(counter_nxt))
  `SHDRBG_ASSERT_NEXT(a_counter_hold, clk, rst_n, !take, $stable(counter_r))
  `SHDRBG_ASSERT_IMPL(a_skid_implies_out, clk, rst_n, !en, out_valid)
  `SHDRBG_ASSERT_NEXT(a_tail_held, clk, rst_n, pipe_valid[NS-1] && !en, pipe_valid[NS-1])

endmodule

[bench/siphash_drbg_check.sv]
// Scoreboard for the SipHash-2-4 counter DRBG: mirrors the key registers and the counter,
// predicts each random word on input transfer and compares it on output transfer.
// Depends on shdrbg_pkg for the lane type and SipHash constants.
`timescale 1ns / 1ps

module siphash_drbg_check (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [shdrbg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [shdrbg_pkg::WORD_W-1:0]          cfg_wdata,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic                                   in_advance,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic [shdrbg_pkg::RAND_W-1:0]          out_random_word,
  input  logic [shdrbg_pkg::WORD_W-1:0]          out_sequence_index,
  output int                                     fail_count,
  output int                                     words_pending
);
  import shdrbg_pkg::*;

  typedef struct packed {
    logic [RAND_W-1:0] word;
    logic [WORD_W-1:0] index;
  } drbg_word_t;

  logic [WORD_W-1:0] seed_lo;
  logic [WORD_W-1:0] seed_hi;
  logic [WORD_W-1:0] next_index;
  drbg_word_t        expected_words[$];

  function automatic logic [WORD_W-1:0] sip_rotl(input logic [WORD_W-1:0] x,
                                                 input int unsigned n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

  function automatic lanes_t sip_round(input lanes_t v);
    v.a = v.a + v.b;
    v.b = sip_rotl(v.b, 13) ^ v.a;
    v.a = sip_rotl(v.a, 32);
    v.c = v.c + v.d;
    v.d = sip_rotl(v.d, 16) ^ v.c;
    v.a = v.a + v.d;
    v.d = sip_rotl(v.d, 21) ^ v.a;
    v.c = v.c + v.b;
    v.b = sip_rotl(v.b, 17) ^ v.c;
    v.c = sip_rotl(v.c, 32);
    return v;
  endfunction

  // two compression rounds per 64-bit message word
  function automatic lanes_t sip_absorb(input lanes_t v, input logic [WORD_W-1:0] m);
    v.d = v.d ^ m;
    v = sip_round(v);
    v = sip_round(v);
    v.a = v.a ^ m;
    return v;
  endfunction

  function automatic logic [RAND_W-1:0] siphash_low_word(input logic [WORD_W-1:0] msg,
                                                         input logic [WORD_W-1:0] k0,
                                                         input logic [WORD_W-1:0] k1);
    lanes_t            v;
    logic [WORD_W-1:0] h;
    v.a = SIP_INIT0 ^ k0;
    v.b = SIP_INIT1 ^ k1;
    v.c = SIP_INIT2 ^ k0;
    v.d = SIP_INIT3 ^ k1;
    v = sip_absorb(v, msg);
    v = sip_absorb(v, SIP_LEN_BLOCK);
    v.c = v.c ^ SIP_FINAL_XOR;
    for (int r = 0; r < 4; r++)
      v = sip_round(v);
    h = v.a ^ v.b ^ v.c ^ v.d;
    return h[RAND_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    drbg_word_t want;
    if (!rst_n) begin
      seed_lo    = '0;
      seed_hi    = '0;
      next_index = '0;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_FIRST:  seed_lo = cfg_wdata;
          REG_KEY_SECOND: seed_hi = cfg_wdata;
          default: ;
        endcase
      end
      // a transfer with advance low makes no word and leaves the counter alone
      if (in_valid && in_ready && in_advance) begin
        want.word  = siphash_low_word(next_index, seed_lo, seed_hi);
        want.index = next_index;
        expected_words.push_back(want);
        next_index = next_index + 1'b1;
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", {32'b0, out_random_word}, '0);
        end else begin
          want = expected_words.pop_front();
          if (out_random_word !== want.word)
            report_mismatch("random_word", {32'b0, out_random_word}, {32'b0, want.word});
          if (out_sequence_index !== want.index)
            report_mismatch("sequence_index", out_sequence_index, want.index);
        end
      end
    end
    words_pending = expected_words.size();
  end

endmodule

[bench/tb_siphash_counter_drbg.sv]
// Top-level bench for siphash_counter_drbg: clock, reset, key writes, request bursts
// and output backpressure. Depends on shdrbg_pkg and siphash_drbg_check for checking.
`timescale 1ns / 1ps

module tb_siphash_counter_drbg;
  import shdrbg_pkg::*;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [WORD_W-1:0]    cfg_wdata  = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_advance = 1'b0;
  logic                 out_ready  = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  logic [RAND_W-1:0]    out_random_word;
  logic [WORD_W-1:0]    out_sequence_index;

  int fail_count;
  int words_pending;
  int requests_sent = 0;
  int ready_run     = 0;

  always #10 clk = ~clk;

  siphash_counter_drbg dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_advance         (in_advance),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_random_word    (out_random_word),
    .out_sequence_index (out_sequence_index)
  );

  siphash_drbg_check u_word_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_advance         (in_advance),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_random_word    (out_random_word),
    .out_sequence_index (out_sequence_index),
    .fail_count         (fail_count),
    .words_pending      (words_pending)
  );

  // receiver: runs of stall, runs of ready, and single-cycle flicker
  always @(negedge clk) begin
    if (ready_run == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          out_ready <= 1'b0;
          ready_run <= $urandom_range(1, 24);
        end
        1: begin
          out_ready <= 1'($urandom_range(0, 1));
          ready_run <= 0;
        end
        default: begin
          out_ready <= 1'b1;
          ready_run <= $urandom_range(1, 48);
        end
      endcase
    end else begin
      ready_run <= ready_run - 1;
    end
  end

  // holds the request until its transfer, returns at the following falling edge
  task automatic send_request(input logic adv);
    in_valid   = 1'b1;
    in_advance = adv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (adv) requests_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    in_valid   = 1'b0;
    in_advance = 1'($urandom_range(0, 1));
    repeat (cycles) @(negedge clk);
  endtask

  // every word has left once nothing is pending; extra cycles are settle margin
  task automatic wait_idle();
    in_valid = 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic run_random(input int n_requests);
    int goal;
    int burst;
    goal = requests_sent + n_requests;
    while (requests_sent < goal) begin
      burst = $urandom_range(1, 32);
      repeat (burst) send_request($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 3) != 0)
        pause_sender($urandom_range(1, 8));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset keys, back-to-back words, requests with advance low in between
    send_request(1'b1);
    send_request(1'b1);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
    pause_sender(3);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    wait_idle();

    // key extremes; counter keeps running across key changes
    write_key(REG_KEY_FIRST, '1);
    send_request(1'b1);
    send_request(1'b1);
    send_request(1'b1);
    wait_idle();
    write_key(REG_KEY_FIRST, '0);
    write_key(REG_KEY_SECOND, '1);
    send_request(1'b1);
    send_request(1'b1);
    send_request(1'b1);
    wait_idle();
    write_key(REG_KEY_FIRST, '1);
    send_request(1'b1);
    send_request(1'b1);
    wait_idle();
    write_key(REG_KEY_FIRST, 64'h5555555555555555);
    write_key(REG_KEY_SECOND, 64'haaaaaaaaaaaaaaaa);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
    wait_idle();

    // counter wrap at 2^64 is out of reach from reset
    repeat (5) begin
      write_key(REG_KEY_FIRST, {$urandom, $urandom});
      write_key(REG_KEY_SECOND, {$urandom, $urandom});
      run_random(100);
      wait_idle();
    end

    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
